FILE: hw/rtl/typed_value_stream_decoder_core_macros.svh
// Assertion macros shared by the typed value stream decoder checkers.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef TYPED_VALUE_STREAM_DECODER_CORE_MACROS_SVH
`define TYPED_VALUE_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define TVSD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define TVSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/tvsd_pkg.sv
// Shared types, codes and constants of the typed value stream decoder.
// No dependencies; used by tvsd_step, the top level and the checker.
package tvsd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  localparam logic [15:0] REV_3_0 = 16'h0300;

  // Type code bytes on the wire
  localparam logic [7:0] TC_BOOL      = 8'h00;
  localparam logic [7:0] TC_DOUBLE    = 8'h01;
  localparam logic [7:0] TC_STRING    = 8'h02;
  localparam logic [7:0] TC_RAW       = 8'h03;
  localparam logic [7:0] TC_BOOL_ARR  = 8'h10;
  localparam logic [7:0] TC_DBL_ARR   = 8'h11;
  localparam logic [7:0] TC_STR_ARR   = 8'h12;
  localparam logic [7:0] TC_RPC       = 8'h20;

  // Decoded value types
  localparam logic [2:0] VT_BOOL      = 3'd0;
  localparam logic [2:0] VT_DOUBLE    = 3'd1;
  localparam logic [2:0] VT_STRING    = 3'd2;
  localparam logic [2:0] VT_RAW       = 3'd3;
  localparam logic [2:0] VT_BOOL_ARR  = 3'd4;
  localparam logic [2:0] VT_DBL_ARR   = 3'd5;
  localparam logic [2:0] VT_STR_ARR   = 3'd6;
  localparam logic [2:0] VT_RPC       = 3'd7;

  // Result kinds
  localparam logic [2:0] KIND_ELEM     = 3'd0;
  localparam logic [2:0] KIND_STR_BYTE = 3'd1;
  localparam logic [2:0] KIND_EMPTY    = 3'd2;
  localparam logic [2:0] KIND_COUNT    = 3'd3;
  localparam logic [2:0] KIND_ERROR    = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd1;
  localparam logic [1:0] ERR_TOO_EARLY = 2'd2;
  localparam logic [1:0] ERR_OVERLONG = 2'd3;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_BOOL   = 7'b0000010,
    PH_DOUBLE = 7'b0000100,
    PH_LEN16  = 7'b0001000,
    PH_LEB    = 7'b0010000,
    PH_BYTES  = 7'b0100000,
    PH_COUNT  = 7'b1000000
  } phase_t;

  // Parser state except the string length, whose width is a parameter
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  cur_type;
    logic [3:0]  byte_cnt;
    logic [63:0] dbl;
    logic [5:0]  leb_shift;
    logic [7:0]  elem_rem;
    logic [7:0]  elem_pos;
  } ctx_t;

  typedef struct packed {
    logic [2:0]  value_type;
    logic [2:0]  item_kind;
    logic [63:0] item_data;
    logic [7:0]  element_index;
    logic        end_of_string;
    logic        last;
    logic [1:0]  error_code;
  } res_t;

endpackage

FILE: hw/rtl/typed_value_stream_decoder_core.sv
// Typed value stream decoder: type byte plus payload in, decoded results out.
// Depends on tvsd_pkg and tvsd_step.
//
//  channel | direction | tdata / data             | tuser / flags
//  in_     | slave     | data_byte                | begin_value
//  out_    | master    | item_data, element_index,| value_type, item_kind,
//          |           | end_of_string            | error_code; tlast = last
//  cfg_    | slave     | protocol_revision        | -
//
// One byte per clock sustained while out_tready keeps up: an input register feeds the parse
// logic, whose result lands in the output register, from which out_ is driven.
// A byte that yields no result still takes one pass through the parse stage.
// rst_n (synchronous) clears the parser to idle and the revision to 0x0300.
// While a result waits on out_tready the parse stage holds, so the input
// register fills; in_tready drops only when both are full and out_tready is low.
module typed_value_stream_decoder_core import tvsd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] begin_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [63:0] item_data, [71:64] element_index,
                                  // [72] end_of_string, [79:73] zero
  output logic [7:0]  out_tuser,  // [2:0] value_type, [5:3] item_kind, [7:6] error_code
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // protocol_revision
);

  logic                   stg_vld_r;
  logic [7:0]             stg_byte_r;
  logic                   stg_begin_r;
  logic                   adv;
  logic [15:0]            rev_r;
  ctx_t                   ctx_r;
  ctx_t                   ctx_nxt;
  logic [LENGTH_BITS-1:0] len_r;
  logic [LENGTH_BITS-1:0] len_nxt;
  logic                   res_vld;
  res_t                   res;
  logic                   out_vld_r;
  res_t                   out_res_r;

  assign adv       = stg_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !stg_vld_r || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r <= REV_3_0;
    end else if (cfg_valid) begin
      rev_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_tready) begin
      stg_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_byte_r  <= in_tdata;
      stg_begin_r <= in_tuser;
    end
  end

  tvsd_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .ctx         (ctx_r),
    .len         (len_r),
    .rev         (rev_r),
    .data_byte   (stg_byte_r),
    .begin_value (stg_begin_r),
    .ctx_nxt     (ctx_nxt),
    .len_nxt     (len_nxt),
    .res_vld     (res_vld),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '{phase: PH_IDLE, default: '0};
      len_r <= '0;
    end else if (adv) begin
      ctx_r <= ctx_nxt;
      len_r <= len_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_res_r.end_of_string, out_res_r.element_index,
                       out_res_r.item_data};
  assign out_tuser  = {out_res_r.error_code, out_res_r.item_kind, out_res_r.value_type};
  assign out_tlast  = out_res_r.last;

endmodule

FILE: hw/rtl/tvsd_step.sv
// Next-state and result logic of the decoder for one registered byte.
// Depends on tvsd_pkg.
module tvsd_step import tvsd_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  ctx_t                   ctx,
  input  logic [LENGTH_BITS-1:0] len,
  input  logic [15:0]            rev,
  input  logic [7:0]             data_byte,
  input  logic                   begin_value,
  output ctx_t                   ctx_nxt,
  output logic [LENGTH_BITS-1:0] len_nxt,
  output logic                   res_vld,
  output res_t                   res
);

  localparam logic [5:0] LB6 = 6'(LENGTH_BITS);

  logic                   fin;
  logic [2:0]             fin_kind;
  logic [63:0]            fin_data;
  logic                   fin_eos;
  logic                   fin_last;
  logic [7:0]             rem_dec;
  logic                   start_el;
  logic                   do_err;
  logic [1:0]             err_code;
  logic                   is_arr;
  logic                   nxt_arr;
  logic [63:0]            dbl_new;
  logic [3:0]             cnt_new;
  logic [LENGTH_BITS-1:0] len_new;
  logic [6:0]             payload;
  logic [LENGTH_BITS+6:0] leb_wide;
  logic                   leb_ovf;
  logic [6:0]             leb_sum;

  assign is_arr   = (ctx.cur_type == VT_BOOL_ARR) || (ctx.cur_type == VT_DBL_ARR) ||
                    (ctx.cur_type == VT_STR_ARR);
  assign dbl_new  = {ctx.dbl[55:0], data_byte};
  assign cnt_new  = ctx.byte_cnt + 4'd1;
  assign payload  = data_byte[6:0];
  assign leb_wide = {{LENGTH_BITS{1'b0}}, payload} << ctx.leb_shift;
  assign leb_ovf  = (payload != 7'd0) &&
                    ((ctx.leb_shift >= LB6) || (|leb_wide[LENGTH_BITS+6:LENGTH_BITS]));
  assign leb_sum  = {1'b0, ctx.leb_shift} + 7'd7;
  assign rem_dec  = ctx.elem_rem - 8'd1;

  always_comb begin
    ctx_nxt  = ctx;
    len_nxt  = len;
    res_vld  = 1'b0;
    res      = '0;
    fin      = 1'b0;
    fin_kind = KIND_ELEM;
    fin_data = '0;
    fin_eos  = 1'b0;
    fin_last = 1'b1;
    start_el = 1'b0;
    do_err   = 1'b0;
    err_code = ERR_NONE;
    len_new  = len;
    nxt_arr  = 1'b0;

    if (begin_value) begin
      ctx_nxt.elem_rem = '0;
      ctx_nxt.elem_pos = '0;
      case (data_byte)
        TC_BOOL:     ctx_nxt.cur_type = VT_BOOL;
        TC_DOUBLE:   ctx_nxt.cur_type = VT_DOUBLE;
        TC_STRING:   ctx_nxt.cur_type = VT_STRING;
        TC_RAW:      ctx_nxt.cur_type = VT_RAW;
        TC_BOOL_ARR: ctx_nxt.cur_type = VT_BOOL_ARR;
        TC_DBL_ARR:  ctx_nxt.cur_type = VT_DBL_ARR;
        TC_STR_ARR:  ctx_nxt.cur_type = VT_STR_ARR;
        TC_RPC:      ctx_nxt.cur_type = VT_RPC;
        default: begin
          ctx_nxt.cur_type = VT_BOOL;
          do_err           = 1'b1;
          err_code         = ERR_UNKNOWN;
        end
      endcase
      if (!do_err) begin
        if (((ctx_nxt.cur_type == VT_RAW) || (ctx_nxt.cur_type == VT_RPC)) &&
            (rev < REV_3_0)) begin
          do_err   = 1'b1;
          err_code = ERR_TOO_EARLY;
        end else if ((ctx_nxt.cur_type == VT_BOOL_ARR) ||
                     (ctx_nxt.cur_type == VT_DBL_ARR) ||
                     (ctx_nxt.cur_type == VT_STR_ARR)) begin
          ctx_nxt.phase = PH_COUNT;
        end else begin
          start_el = 1'b1;
        end
      end
    end else begin
      case (ctx.phase)
        PH_IDLE: begin
          // stray payload byte outside a value: drop
        end
        PH_BOOL: begin
          fin      = 1'b1;
          fin_data = {63'd0, |data_byte};
        end
        PH_DOUBLE: begin
          ctx_nxt.dbl      = dbl_new;
          ctx_nxt.byte_cnt = cnt_new;
          if (cnt_new >= 4'd8) begin
            fin      = 1'b1;
            fin_data = dbl_new;
          end
        end
        PH_LEN16: begin
          len_new          = {{(LENGTH_BITS-16){1'b0}}, len[7:0], data_byte};
          len_nxt          = len_new;
          ctx_nxt.byte_cnt = cnt_new;
          if (cnt_new >= 4'd2) begin
            if (len_new == '0) begin
              fin      = 1'b1;
              fin_kind = KIND_EMPTY;
              fin_eos  = 1'b1;
            end else begin
              ctx_nxt.phase = PH_BYTES;
            end
          end
        end
        PH_LEB: begin
          if (leb_ovf) begin
            do_err   = 1'b1;
            err_code = ERR_OVERLONG;
          end else begin
            len_new = len | leb_wide[LENGTH_BITS-1:0];
            len_nxt = len_new;
            if (data_byte[7]) begin
              // saturate the shift so it never wraps back into range
              ctx_nxt.leb_shift = (leb_sum > 7'd63) ? 6'd63 : leb_sum[5:0];
            end else if (len_new == '0) begin
              fin      = 1'b1;
              fin_kind = KIND_EMPTY;
              fin_eos  = 1'b1;
            end else begin
              ctx_nxt.phase = PH_BYTES;
            end
          end
        end
        PH_BYTES: begin
          len_new = len - LENGTH_BITS'(1);
          len_nxt = len_new;
          if (len_new == '0) begin
            fin      = 1'b1;
            fin_kind = KIND_STR_BYTE;
            fin_data = {56'd0, data_byte};
            fin_eos  = 1'b1;
          end else begin
            res_vld           = 1'b1;
            res.item_kind     = KIND_STR_BYTE;
            res.item_data     = {56'd0, data_byte};
            res.element_index = (ctx.cur_type == VT_STR_ARR) ? ctx.elem_pos : 8'd0;
          end
        end
        PH_COUNT: begin
          ctx_nxt.elem_rem = data_byte;
          ctx_nxt.elem_pos = '0;
          res_vld          = 1'b1;
          res.item_kind    = KIND_COUNT;
          res.item_data    = {56'd0, data_byte};
          if (data_byte == 8'd0) begin
            ctx_nxt.phase = PH_IDLE;
            res.last      = 1'b1;
          end else begin
            start_el = 1'b1;
          end
        end
        default: begin
          ctx_nxt.phase = PH_IDLE;
        end
      endcase
    end

    // close one element; arrays advance their position and count down
    if (fin) begin
      res_vld           = 1'b1;
      res.item_kind     = fin_kind;
      res.item_data     = fin_data;
      res.end_of_string = fin_eos;
      if (is_arr) begin
        res.element_index = ctx.elem_pos;
        ctx_nxt.elem_rem  = rem_dec;
        ctx_nxt.elem_pos  = ctx.elem_pos + 8'd1;
        fin_last          = (rem_dec == 8'd0);
      end
      res.last = fin_last;
      if (fin_last) begin
        ctx_nxt.phase = PH_IDLE;
      end else begin
        start_el = 1'b1;
      end
    end

    if (start_el) begin
      ctx_nxt.byte_cnt = '0;
      ctx_nxt.dbl      = '0;
      case (ctx_nxt.cur_type)
        VT_BOOL, VT_BOOL_ARR:  ctx_nxt.phase = PH_BOOL;
        VT_DOUBLE, VT_DBL_ARR: ctx_nxt.phase = PH_DOUBLE;
        default: begin
          ctx_nxt.phase     = (rev < REV_3_0) ? PH_LEN16 : PH_LEB;
          ctx_nxt.leb_shift = '0;
          len_nxt           = '0;
        end
      endcase
    end

    if (do_err) begin
      nxt_arr = (ctx_nxt.cur_type == VT_BOOL_ARR) || (ctx_nxt.cur_type == VT_DBL_ARR) ||
                (ctx_nxt.cur_type == VT_STR_ARR);
      ctx_nxt.phase     = PH_IDLE;
      res_vld           = 1'b1;
      res               = '0;
      res.item_kind     = KIND_ERROR;
      res.element_index = nxt_arr ? ctx_nxt.elem_pos : 8'd0;
      res.last          = 1'b1;
      res.error_code    = err_code;
    end

    res.value_type = ctx_nxt.cur_type;
  end

endmodule

FILE: hw/rtl/tvsd_checker.sv
// Port-level checks of the typed value stream decoder, bound to the top level.
// Depends on tvsd_pkg and typed_value_stream_decoder_core_macros.svh.
`include "typed_value_stream_decoder_core_macros.svh"

module tvsd_checker import tvsd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [7:0]  out_tuser,
  input logic        out_tlast
);

  logic [2:0] kind;
  logic [1:0] err;
  logic       eos;

  assign kind = out_tuser[5:3];
  assign err  = out_tuser[7:6];
  assign eos  = out_tdata[72];

  `TVSD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")
  `TVSD_ASSERT_NOW(a_err_last, out_tvalid && (kind == KIND_ERROR), out_tlast && (out_tdata[63:0] == 64'd0), "error must close the value with no data")
  `TVSD_ASSERT_NOW(a_err_code, out_tvalid, (err != ERR_NONE) == (kind == KIND_ERROR), "error code and kind disagree")
  `TVSD_ASSERT_NOW(a_eos_kind, out_tvalid && eos, (kind == KIND_STR_BYTE) || (kind == KIND_EMPTY), "end of string on a non-string result")

endmodule

bind typed_value_stream_decoder_core tvsd_checker u_tvsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
